// ===== rtl/lags_pkg.sv =====
package lags_pkg;

    // Store geometry; the row stride is always the full store width
    localparam int GRID_MAX_W = 256;
    localparam int GRID_MAX_H = 256;
    localparam int COL_W      = $clog2(GRID_MAX_W);
    localparam int ROW_W      = $clog2(GRID_MAX_H);
    localparam int CELLS      = GRID_MAX_W * GRID_MAX_H;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CW_SIZE    = COL_W + 1;
    localparam int RW_SIZE    = ROW_W + 1;

    // Register file
    localparam int CFG_W   = 9;
    localparam int CFG_IDX = 1;
    localparam logic [CFG_IDX-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX-1:0] REG_HEIGHT = 1'b1;

    // Request operations
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Cell codes
    localparam logic [1:0] CELL_DEAD  = 2'd0;
    localparam logic [1:0] CELL_ALIVE = 2'd1;
    localparam logic [1:0] CELL_WALL  = 2'd2;

    // Neighborhood walk: tap 0 is the center, taps 1..8 the neighbors
    localparam int TAP_W = 4;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(8);
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_MIN = CNT_W'(2);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_ADV_TAP,
        S_ADV_LAST,
        S_ADV_WR,
        S_ADV_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_load;
        logic tap_issue;
        logic tap_last;
        logic cell_wr;
        logic adv_done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rd_ok;
        logic adv;
        logic tap_end;
        logic sweep_end;
    } t_status;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(GRID_MAX_W) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/life_automaton_grid_step.sv =====
// Toroidal life engine with wall cells over two 256 x 256 stores of 2-bit cells.
// After reset the block clears both stores, one cell a cycle, before it takes its
// first request; configuration writes are taken at any time.
// A write request is stored when it is accepted and its result appears the next cycle;
// a read request loads its result from the registered read of the cell store.
// An advance walks every store cell through the single read port of the store,
// nine reads, one count step and one write per cell, in the tap, last-tap and write
// states, and loads its result once the sweep has ended and the output is free.
// One request is in work at a time.
module life_automaton_grid_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lags_pkg::CFG_IDX-1:0]  i_cfg_index,
    input  logic [lags_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_column,
    input  logic [7:0]                    i_row,
    input  logic [1:0]                    i_cell_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_cell_state,
    output logic                          o_address_error
);
    import lags_pkg::*;

    t_cmd    cmd;
    t_status st;

    lags_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    lags_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_cell_value    (i_cell_value),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_cell_state    (o_cell_state),
        .o_address_error (o_address_error),
        .i_cmd           (cmd),
        .o_st            (st)
    );

endmodule

// ===== rtl/lags_ctrl.sv =====
module lags_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lags_pkg::t_status i_st,
    output lags_pkg::t_cmd    o_cmd
);
    import lags_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_st.sweep_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && i_st.out_free) begin
                    if (i_st.rd_ok)    n_state = S_RD_WAIT;
                    else if (i_st.adv) n_state = S_ADV_TAP;
                end
            end
            S_RD_WAIT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            S_ADV_TAP: begin
                if (i_st.tap_end) n_state = S_ADV_LAST;
            end
            S_ADV_LAST: n_state = S_ADV_WR;
            S_ADV_WR: begin
                n_state = i_st.sweep_end ? S_ADV_DONE : S_ADV_TAP;
            end
            S_ADV_DONE: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_ready      = i_st.out_free;
                o_cmd.accept = i_valid && i_st.out_free;
            end
            S_RD_WAIT:  o_cmd.rd_load   = i_st.out_free;
            S_ADV_TAP:  o_cmd.tap_issue = 1'b1;
            S_ADV_LAST: o_cmd.tap_last  = 1'b1;
            S_ADV_WR:   o_cmd.cell_wr   = 1'b1;
            S_ADV_DONE: o_cmd.adv_done  = i_st.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lags_dpath.sv =====
module lags_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lags_pkg::CFG_IDX-1:0]  i_cfg_index,
    input  logic [lags_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_column,
    input  logic [7:0]                    i_row,
    input  logic [1:0]                    i_cell_value,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [1:0]                    o_cell_state,
    output logic                          o_address_error,
    input  lags_pkg::t_cmd                i_cmd,
    output lags_pkg::t_status             o_st
);
    import lags_pkg::*;

    logic [1:0] mem_a [CELLS];
    logic [1:0] mem_b [CELLS];

    logic [CFG_W-1:0]  r_w, r_h;
    logic              r_active;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [TAP_W-1:0]  r_tap;
    logic [CNT_W-1:0]  r_count;
    logic [1:0]        r_center;
    logic [1:0]        r_rd_a, r_rd_b;
    logic              r_out_valid;
    logic [1:0]        r_out_state;
    logic              r_out_err;

    logic [CW_SIZE-1:0] w_eff;
    logic [RW_SIZE-1:0] h_eff;
    logic               user_err;
    logic [ADDR_W-1:0]  user_addr;
    logic [COL_W-1:0]   col_m, col_p, tap_col;
    logic [ROW_W-1:0]   row_m, row_p, tap_row;
    logic [ADDR_W-1:0]  sweep_addr;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [1:0]         wr_data;
    logic               we_a, we_b;
    logic [1:0]         rd_data;
    logic               in_region;
    logic [1:0]         next_cell;
    logic               load_imm;

    // Clamp sizes in use to 1..store size
    always_comb begin
        if (r_w == '0)                   w_eff = CW_SIZE'(1);
        else if (32'(r_w) > GRID_MAX_W)  w_eff = CW_SIZE'(GRID_MAX_W);
        else                             w_eff = CW_SIZE'(r_w);
        if (r_h == '0)                   h_eff = RW_SIZE'(1);
        else if (32'(r_h) > GRID_MAX_H)  h_eff = RW_SIZE'(GRID_MAX_H);
        else                             h_eff = RW_SIZE'(r_h);
    end

    // Decode the request
    assign user_err  = (32'(i_column) >= 32'(w_eff)) || (32'(i_row) >= 32'(h_eff));
    assign user_addr = cell_addr(ROW_W'(i_row), COL_W'(i_column));
    assign o_st.rd_ok = (i_operation == OP_READ) && !user_err;
    assign o_st.adv   = (i_operation == OP_ADVANCE);

    // Wrapped neighbor coordinates of the sweep cell
    always_comb begin
        col_m = (r_col == '0) ? COL_W'(w_eff - CW_SIZE'(1)) : r_col - COL_W'(1);
        col_p = (32'(r_col) + 1 >= 32'(w_eff)) ? '0 : r_col + COL_W'(1);
        row_m = (r_row == '0) ? ROW_W'(h_eff - RW_SIZE'(1)) : r_row - ROW_W'(1);
        row_p = (32'(r_row) + 1 >= 32'(h_eff)) ? '0 : r_row + ROW_W'(1);
        case (r_tap)
            TAP_W'(1): begin tap_col = col_m; tap_row = row_m; end
            TAP_W'(2): begin tap_col = r_col; tap_row = row_m; end
            TAP_W'(3): begin tap_col = col_p; tap_row = row_m; end
            TAP_W'(4): begin tap_col = col_m; tap_row = r_row; end
            TAP_W'(5): begin tap_col = col_p; tap_row = r_row; end
            TAP_W'(6): begin tap_col = col_m; tap_row = row_p; end
            TAP_W'(7): begin tap_col = r_col; tap_row = row_p; end
            TAP_W'(8): begin tap_col = col_p; tap_row = row_p; end
            default:   begin tap_col = r_col; tap_row = r_row; end
        endcase
    end

    assign sweep_addr = cell_addr(r_row, r_col);
    assign rd_addr    = i_cmd.tap_issue ? cell_addr(tap_row, tap_col) : user_addr;
    assign rd_data    = r_active ? r_rd_b : r_rd_a;

    // Life rule for the sweep cell
    assign in_region = (32'(r_col) < 32'(w_eff)) && (32'(r_row) < 32'(h_eff));
    always_comb begin
        next_cell = r_center;
        if (in_region) begin
            if (r_center == CELL_DEAD && r_count == BIRTH_CNT)
                next_cell = CELL_ALIVE;
            else if (r_center == CELL_ALIVE &&
                     (r_count < SURVIVE_MIN || r_count > BIRTH_CNT))
                next_cell = CELL_DEAD;
        end
    end

    // Write port steering
    always_comb begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        wr_addr = sweep_addr;
        wr_data = CELL_DEAD;
        if (i_cmd.clr_wr) begin
            we_a = 1'b1;
            we_b = 1'b1;
        end else if (i_cmd.cell_wr) begin
            we_a    = r_active;
            we_b    = !r_active;
            wr_data = next_cell;
        end else if (i_cmd.accept && i_operation == OP_WRITE && !user_err) begin
            we_a    = !r_active;
            we_b    = r_active;
            wr_addr = user_addr;
            wr_data = (i_cell_value == 2'd3) ? CELL_DEAD : i_cell_value;
        end
    end

    // Cell stores
    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[wr_addr] <= wr_data;
        r_rd_a <= mem_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) mem_b[wr_addr] <= wr_data;
        r_rd_b <= mem_b[rd_addr];
    end

    // Configuration and store selector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= CFG_W'(256);
            r_h      <= CFG_W'(256);
            r_active <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_WIDTH)  r_w <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == REG_HEIGHT) r_h <= i_cfg_data;
            if (i_cmd.adv_done) r_active <= !r_active;
        end
    end

    // Advance the sweep over every store cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.clr_wr || i_cmd.cell_wr) begin
            if (32'(r_col) == GRID_MAX_W - 1) begin
                r_col <= '0;
                r_row <= (32'(r_row) == GRID_MAX_H - 1) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    assign o_st.sweep_end = (32'(r_col) == GRID_MAX_W - 1) &&
                            (32'(r_row) == GRID_MAX_H - 1);

    // Walk the taps and count alive neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_cmd.tap_issue) begin
            r_tap <= (r_tap == TAP_LAST) ? '0 : r_tap + TAP_W'(1);
        end
    end

    assign o_st.tap_end = (r_tap == TAP_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_issue && r_tap == '0) begin
            r_count <= '0;
        end else if ((i_cmd.tap_issue && r_tap > TAP_W'(1)) || i_cmd.tap_last) begin
            r_count <= r_count + CNT_W'(rd_data == CELL_ALIVE);
        end
        if (i_cmd.tap_issue && r_tap == TAP_W'(1)) r_center <= rd_data;
    end

    // Output register
    assign load_imm      = i_cmd.accept && !o_st.rd_ok && !o_st.adv;
    assign o_st.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_imm || i_cmd.rd_load || i_cmd.adv_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_imm) begin
            r_out_state <= CELL_DEAD;
            r_out_err   <= (i_operation == OP_WRITE || i_operation == OP_READ) && user_err;
        end else if (i_cmd.rd_load) begin
            r_out_state <= rd_data;
            r_out_err   <= 1'b0;
        end else if (i_cmd.adv_done) begin
            r_out_state <= CELL_DEAD;
            r_out_err   <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_state    = r_out_state;
    assign o_address_error = r_out_err;

endmodule

// ===== rtl/lags_chk.sv =====
module lags_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [lags_pkg::CFG_IDX-1:0]  i_cfg_index,
    input logic [lags_pkg::CFG_W-1:0]    i_cfg_data,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [1:0]                    i_operation,
    input logic [7:0]                    i_column,
    input logic [7:0]                    i_row,
    input logic [1:0]                    i_cell_value,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [1:0]                    o_cell_state,
    input logic                          o_address_error
);
    import lags_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_state) && $stable(o_address_error))
        else $error("result changed while stalled");

    // Drop the cell state on an address error
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_address_error |-> o_cell_state == CELL_DEAD)
        else $error("cell state with address error");

    // Never report an unstored cell code
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cell_state != 2'd3)
        else $error("invalid cell code");

    // A write request answers on the next cycle
    a_write_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_operation == OP_WRITE |=> o_valid)
        else $error("write result late");

endmodule

bind life_automaton_grid_step lags_chk u_lags_chk (.*);
